FILE: hw/rtl/msd_pkg.sv
// Shared types, constants and lookup functions of the seven-segment driver.
package msd_pkg;

  localparam int unsigned CHAR_W  = 3;
  localparam int unsigned VALUE_W = 20;
  localparam int unsigned SEG_W   = 8;
  localparam int unsigned PORT_W  = 6;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ZEROS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_SECOND = 2'd2;

  localparam logic [SEG_W-1:0] SEG_POINT = 8'h80;

  // Reciprocal of ten scaled by 2^23; exact for every 20-bit dividend.
  localparam int unsigned RECIP_SHIFT = 23;
  localparam logic [VALUE_W+3:0] RECIP_TEN = 24'd838861;

  // One item as it moves along the row of digit cells.
  typedef struct packed {
    logic                 valid;
    logic                 tick;
    logic                 sel;
    logic [VALUE_W-1:0]   value;
    logic [CHAR_W-1:0]    char_idx;
    logic [SEG_W-1:0]     pat_first;
    logic [SEG_W-1:0]     pat_second;
  } msd_item_t;

  // Settings that one cell needs.
  typedef struct packed {
    logic show_zeros;
    logic point_first;
    logic point_second;
  } msd_cell_cfg_t;

  function automatic logic [SEG_W-1:0] seg_of_digit(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] p;
    unique case (d)
      4'd0:    p = 8'h3F;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5B;
      4'd3:    p = 8'h4F;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6D;
      4'd6:    p = 8'h7D;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h6F;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  // Characters 0..5 drive port bits 2,1,0,3,4,5; higher characters have no pin.
  function automatic logic [CHAR_W-1:0] pin_of_char(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] p;
    unique case (c)
      3'd0:    p = 3'd2;
      3'd1:    p = 3'd1;
      3'd2:    p = 3'd0;
      default: p = c;
    endcase
    return p;
  endfunction

  function automatic logic mask_bit(input logic [PORT_W-1:0] m, input int unsigned idx);
    logic b;
    b = 1'b0;
    if (idx < PORT_W) begin
      b = m[idx[CHAR_W-1:0]];
    end
    return b;
  endfunction

endpackage

FILE: hw/rtl/msd_if.sv
// Valid/ready channel interfaces for set/tick items and display results.
interface msd_in_if;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic                 display_sel;
  logic [19:0]          shown_value;

  modport source (output valid, kind, display_sel, shown_value, input ready);
  modport sink   (input valid, kind, display_sel, shown_value, output ready);
endinterface

interface msd_out_if;
  logic                 valid;
  logic                 ready;
  logic [15:0]          shift_word;
  logic [5:0]           enable_bits_n;
  logic [2:0]           char_index;

  modport source (output valid, shift_word, enable_bits_n, char_index, input ready);
  modport sink   (input valid, shift_word, enable_bits_n, char_index, output ready);
endinterface

FILE: hw/rtl/msd_cell.sv
// One digit cell: stores a character of both displays and passes items on.
module msd_cell #(
  parameter int unsigned POS   = 0,
  parameter bit          UNITS = 1'b0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  msd_pkg::msd_cell_cfg_t cfg_i,
  input  msd_pkg::msd_item_t     item_i,
  output msd_pkg::msd_item_t     item_o
);
  import msd_pkg::*;

  logic [DIGIT_W-1:0] dig_q [2];
  logic [DIGIT_W-1:0] dig_d;
  logic               lit_q [2];
  logic               lit_d;
  logic [2*VALUE_W+3:0] prod;
  logic [VALUE_W-1:0] quot;
  logic [VALUE_W-1:0] rem;
  logic               write;
  logic               pick;
  msd_item_t          item_q;
  msd_item_t          item_d;

  // Strip off the least significant decimal digit of the remaining value.
  always_comb begin
    prod  = (2*VALUE_W+4)'(item_i.value) * (2*VALUE_W+4)'(RECIP_TEN);
    quot  = prod[RECIP_SHIFT+VALUE_W-1:RECIP_SHIFT];
    rem   = item_i.value - ((quot << 3) + (quot << 1));
    dig_d = rem[DIGIT_W-1:0];
    // Lit when this or a more significant digit is nonzero, in the units cell, or when zeros are shown.
    lit_d = UNITS || (item_i.value != '0) || cfg_i.show_zeros;
  end

  assign write = adv_i && item_i.valid && !item_i.tick;
  assign pick  = item_i.valid && item_i.tick && (item_i.char_idx == CHAR_W'(POS));

  always_comb begin
    item_d = item_i;
    if (!item_i.tick) begin
      item_d.value = quot;
    end
    if (pick) begin
      item_d.pat_first  = (lit_q[0] ? seg_of_digit(dig_q[0]) : '0)
                          | (cfg_i.point_first ? SEG_POINT : '0);
      item_d.pat_second = (lit_q[1] ? seg_of_digit(dig_q[1]) : '0)
                          | (cfg_i.point_second ? SEG_POINT : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_q[0] <= '0;
      dig_q[1] <= '0;
      lit_q[0] <= 1'b0;
      lit_q[1] <= 1'b0;
    end else if (write) begin
      dig_q[item_i.sel] <= dig_d;
      lit_q[item_i.sel] <= lit_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (adv_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

FILE: hw/rtl/multiplexed_seven_segment_driver.sv
// Driver for two multiplexed six-digit seven-segment displays.
//
// Items arrive on in_i. A set-value item (kind 0) loads a binary value, saturated to
// all nines, into the display that display_sel picks; it gives no result. A tick
// (kind 1) advances the active character and gives one result on out_o: the
// 16-bit shift word (display two in the upper byte) and the active-low enable bits.
// Configuration writes go through cfg_we_i/cfg_idx_i/cfg_data_i; the user must make
// them only while no item is in flight, as the block does not enforce this.
// Each item walks the row of digit cells, units cell first, one cell per cycle unless
// stalled; a tick's result is then registered in the output register. One item is
// taken every cycle unless stalled; the digit-by-ten step of each cell sets the
// per-cycle path. Reset blanks both displays and clears every register but the
// output data; the first tick shows character 1. If the receiver stalls, the output
// register holds its result; the row runs until a second tick at its end stops it.
module multiplexed_seven_segment_driver #(
  parameter int unsigned NUM_CHARS = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [msd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [msd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  msd_in_if.sink                            in_i,
  msd_out_if.source                         out_o
);
  import msd_pkg::*;

  localparam longint unsigned LIMIT = 10**NUM_CHARS - 1;

  logic               show_zeros_q;
  logic [PORT_W-1:0]  point_first_q;
  logic [PORT_W-1:0]  point_second_q;
  logic [CHAR_W-1:0]  active_q;
  logic [CHAR_W:0]    char_inc;
  logic [CHAR_W-1:0]  char_next;
  logic [VALUE_W-1:0] value_sat;
  logic               adv;
  logic               stall;
  msd_item_t          items [NUM_CHARS+1];
  msd_item_t          last;

  logic               out_valid_q;
  logic [2*SEG_W-1:0] shift_q;
  logic [PORT_W-1:0]  enable_q;
  logic [CHAR_W-1:0]  char_q;
  logic [7:0]         pin_hot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      show_zeros_q   <= 1'b0;
      point_first_q  <= '0;
      point_second_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SHOW_ZEROS:   show_zeros_q   <= cfg_data_i[0];
        CFG_POINT_FIRST:  point_first_q  <= cfg_data_i[PORT_W-1:0];
        CFG_POINT_SECOND: point_second_q <= cfg_data_i[PORT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    char_inc  = {1'b0, active_q} + 1'b1;
    char_next = (char_inc >= (CHAR_W+1)'(NUM_CHARS)) ? '0 : char_inc[CHAR_W-1:0];
    value_sat = (64'(in_i.shown_value) > LIMIT) ? VALUE_W'(LIMIT) : in_i.shown_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (in_i.valid && adv && in_i.kind) begin
      active_q <= char_next;
    end
  end

  always_comb begin
    items[0]            = '0;
    items[0].valid      = in_i.valid;
    items[0].tick       = in_i.kind;
    items[0].sel        = in_i.display_sel;
    items[0].value      = value_sat;
    items[0].char_idx   = char_next;
  end

  assign last  = items[NUM_CHARS];
  // Only a tick at the end of the row needs the output register.
  assign stall = last.valid && last.tick && out_valid_q && !out_o.ready;
  assign adv   = !stall;
  assign in_i.ready = adv;

  for (genvar k = 0; k < NUM_CHARS; k++) begin : g_cell
    msd_cell_cfg_t cell_cfg;
    assign cell_cfg.show_zeros   = show_zeros_q;
    assign cell_cfg.point_first  = mask_bit(point_first_q, NUM_CHARS - 1 - k);
    assign cell_cfg.point_second = mask_bit(point_second_q, NUM_CHARS - 1 - k);

    msd_cell #(
      .POS   (NUM_CHARS - 1 - k),
      .UNITS (k == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .cfg_i  (cell_cfg),
      .item_i (items[k]),
      .item_o (items[k+1])
    );
  end

  assign pin_hot = 8'd1 << pin_of_char(last.char_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= last.valid && last.tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_o.ready) begin
      shift_q  <= {last.pat_second, last.pat_first};
      enable_q <= ~pin_hot[PORT_W-1:0];
      char_q   <= last.char_idx;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.shift_word    = shift_q;
  assign out_o.enable_bits_n = enable_q;
  assign out_o.char_index    = char_q;

endmodule
